>>> rtl/spb_pkg.sv
package spb_pkg;

  localparam int PageBits     = 4096;
  localparam int MaxPages     = 16;
  localparam int OffBits      = $clog2(PageBits);
  localparam int PidBits      = 64 - OffBits;
  localparam int SlotBits     = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int CountBits    = $clog2(MaxPages + 1);
  localparam int WordsPerPage = (PageBits + 63) / 64;
  localparam int WordBits     = (WordsPerPage > 1) ? $clog2(WordsPerPage) : 1;
  localparam int StoreWords   = WordsPerPage * MaxPages;
  localparam int AddrBits     = $clog2(StoreWords);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Classified item handed from front to back
  typedef struct packed {
    logic                is_insert;
    logic                hit;       // page has (or just got) a slot
    logic                dropped;   // insert with no free slot
    logic [AddrBits-1:0] addr;
    logic [5:0]          bit_idx;
    logic [4:0]          count;     // slots in use after this item
  } job_t;

endpackage

>>> rtl/spb_front.sv
module spb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic                cmd,
  input  logic [63:0]         number,
  output logic                job_valid,
  input  logic                job_stall,
  output spb_pkg::job_t       job
);

  logic [spb_pkg::PidBits-1:0]   tags [spb_pkg::MaxPages];
  logic [spb_pkg::CountBits-1:0] count;
  logic [spb_pkg::PidBits-1:0]   pid;
  logic [spb_pkg::OffBits-1:0]   off;
  logic                          hit;
  logic [spb_pkg::SlotBits-1:0]  hit_slot;
  logic [spb_pkg::SlotBits-1:0]  slot;
  logic                          alloc;
  logic                          full;
  logic                          accept;
  logic [spb_pkg::CountBits-1:0] count_next;
  logic [spb_pkg::AddrBits-1:0]  base;

  assign pid    = number[63 -: spb_pkg::PidBits];
  assign off    = number[spb_pkg::OffBits-1:0];
  assign stall  = job_stall;
  assign accept = valid && !stall;
  assign full   = (count == spb_pkg::CountBits'(spb_pkg::MaxPages));

  // Parallel tag compare over allocated slots
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < spb_pkg::MaxPages; i++) begin
      if ((spb_pkg::CountBits'(i) < count) && (tags[i] == pid)) begin
        hit      = 1'b1;
        hit_slot = spb_pkg::SlotBits'(i);
      end
    end
  end

  assign alloc      = (cmd == spb_pkg::CMD_INSERT) && !hit && !full;
  assign slot       = hit ? hit_slot : spb_pkg::SlotBits'(count);
  assign count_next = alloc ? count + 1'b1 : count;
  assign base       = spb_pkg::AddrBits'(slot) * spb_pkg::AddrBits'(spb_pkg::WordsPerPage);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && alloc) begin
      tags[slot] <= pid;
    end
  end

  // Job fields for the back part
  always_comb begin
    job_valid     = valid;
    job.is_insert = (cmd == spb_pkg::CMD_INSERT);
    job.hit       = hit || alloc;
    job.dropped   = (cmd == spb_pkg::CMD_INSERT) && !hit && full;
    job.addr      = base + spb_pkg::AddrBits'(off >> 6);
    job.bit_idx   = off[5:0];
    job.count     = 5'(count_next);
  end

endmodule

>>> rtl/spb_queue.sv
module spb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  spb_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_stall,
  output spb_pkg::job_t out_job
);

  // Two-entry queue
  spb_pkg::job_t ent [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_job   = ent[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= in_job;
    end
  end

endmodule

>>> rtl/spb_back.sv
module spb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_stall,
  input  spb_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          was_present,
  output logic          status,
  output logic [4:0]    pages_in_use
);

  // state codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [63:0]                  mem [spb_pkg::StoreWords];
  logic [63:0]                  rdata;
  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [spb_pkg::AddrBits-1:0] clr_addr;
  spb_pkg::job_t                cur;
  logic                         was;
  logic                         wr_en;
  logic [spb_pkg::AddrBits-1:0] wr_addr;
  logic [63:0]                  wr_data;

  assign job_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign was       = cur.hit && rdata[cur.bit_idx];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == spb_pkg::AddrBits'(spb_pkg::StoreWords - 1))
                  state_next = ST_IDLE;
      ST_IDLE:  if (job_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_DONE;
      ST_DONE:  if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) cur <= job;
  end

  // Memory write: clear sweep or bit set
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur.addr;
    wr_data = rdata | (64'd1 << cur.bit_idx);
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_READ && cur.is_insert && cur.hit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[(state == ST_IDLE) ? job.addr : cur.addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      was_present  <= was;
      status       <= cur.dropped;
      pages_in_use <= cur.count;
    end
  end

endmodule

>>> rtl/sparse_paged_bitset.sv
// sparse_paged_bitset: a set of 64-bit numbers held as a paged bitset.
// Input channel: valid/stall with cmd (0 insert, 1 query) and number.
// Output channel: valid/stall with was_present, status (1 = insert dropped,
// no free page slot) and pages_in_use.
// The front part compares the page id against all 16 tags in parallel,
// allocates a slot on a first insert and queues a job; the back part does a
// read-modify-write of one 64-bit word in the bit store memory.
// From the accepting edge an item passes the queue entry, then the word
// read, then the result register before out_valid. The back part takes
// a new item only after it has read and modified the word and handed off
// the result of the last one.
// After reset the bit store is swept clear, one word a cycle, all 1024 words;
// the queue takes up to two items, then stall stays high until the sweep ends.
// A stalled output holds its result; the queue fills and then stall rises
// on the input.
module sparse_paged_bitset (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [63:0] number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        was_present,
  output logic        status,
  output logic [4:0]  pages_in_use
);

  logic          f_valid;
  logic          f_stall;
  spb_pkg::job_t f_job;
  logic          b_valid;
  logic          b_stall;
  spb_pkg::job_t b_job;

  spb_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .cmd, .number,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  spb_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
    .out_valid(b_valid), .out_stall(b_stall), .out_job(b_job)
  );

  spb_back u_back (
    .clk, .rst, .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
    .out_valid, .out_stall, .was_present, .status, .pages_in_use
  );

  // A dropped insert never reports its bit as present
  a_drop_not_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !was_present) else $error("dropped item present");

  // Page count never exceeds slot count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pages_in_use <= 5'(spb_pkg::MaxPages)) else $error("count range");

  // Held page count and status do not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pages_in_use) && $stable(status))
    else $error("result changed under stall");

endmodule
